// ===== rtl/antenna_look_angle_pointing_macros.svh =====
// assertion macros for the look-angle pointing block
`ifndef ANTENNA_LOOK_ANGLE_POINTING_MACROS_SVH
`define ANTENNA_LOOK_ANGLE_POINTING_MACROS_SVH

// same-cycle implication, held off during reset
`define ALAP_ASSERT_NOW(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("alap check failed");

// next-cycle implication, held off during reset
`define ALAP_ASSERT_NEXT(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("alap check failed");

`endif

// ===== rtl/alap_pkg.sv =====
// shared types and constants for the look-angle pointing block
package alap_pkg;

  // datapath width of both cordic units
  localparam int CW = 54;
  localparam int DIFF_W = 33;
  localparam int PROD_W = 49;
  localparam int SUM_W = 50;

  localparam logic [15:0] INV_GAIN_Q16 = 16'd39797;

  localparam int ATAN_LEN = 24;
  localparam logic [31:0] ATAN_TURN32 [ATAN_LEN] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  typedef enum logic [2:0] {
    CFG_POI_NORTH  = 3'd0,
    CFG_POI_EAST   = 3'd1,
    CFG_POI_DOWN   = 3'd2,
    CFG_AZ_LEFT    = 3'd3,
    CFG_AZ_RIGHT   = 3'd4,
    CFG_EL_LOWER   = 3'd5,
    CFG_EL_UPPER   = 3'd6
  } cfg_reg_t;

endpackage

// ===== rtl/antenna_look_angle_pointing.sv =====
// top level: look angles to a point of interest, with noise and limit clamp
//
//   channel  | direction | handshake              | content
//   s_*      | in        | s_tvalid / s_tready    | ownship position, heading, noise, scan
//   m_*      | out       | m_tvalid / m_tready    | reference azimuth and elevation
//   cfg_*    | in        | cfg_valid / cfg_ready  | register index and write data
//
// one beat enters per cycle unless m_tready holds the pipeline; the two cordic
// pipelines run in series, one iteration per stage
// reset clears all valid bits and loads the register reset values
// the whole pipeline holds while a result waits on m_tready; cfg_ready is always high
module antenna_look_angle_pointing #(
  parameter int CORDIC_STAGES = 16,
  parameter int ANGLE_BITS = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // own_north, own_east, own_down, heading_sine, heading_cosine,
  // az_noise, el_noise, scan_width, scan_height
  input  logic [191:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // ref_azimuth, ref_elevation
  output logic [31:0]  m_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  alap_pkg::cfg_reg_t cfg_index,
  input  logic [31:0]  cfg_data
);
  import alap_pkg::*;

  localparam int PAY1_W = DIFF_W + 64;
  localparam int PAY2_W = 16 + 64;
  localparam int ANG_SD = (ANGLE_BITS > 16) ? ANGLE_BITS - 16 : 0;
  localparam int ANG_SU = (ANGLE_BITS < 16) ? 16 - ANGLE_BITS : 0;

  logic signed [31:0] poi_north, poi_east, poi_down;
  logic signed [15:0] az_left, az_right, el_lower, el_upper;

  logic en;
  assign en = !m_tvalid || m_tready;
  assign s_tready = en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      poi_north <= '0;
      poi_east  <= '0;
      poi_down  <= '0;
      az_left   <= -16'sd32768;
      az_right  <= 16'sd32767;
      el_lower  <= -16'sd16384;
      el_upper  <= 16'sd16384;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_POI_NORTH: poi_north <= cfg_data;
        CFG_POI_EAST:  poi_east  <= cfg_data;
        CFG_POI_DOWN:  poi_down  <= cfg_data;
        CFG_AZ_LEFT:   az_left   <= cfg_data[15:0];
        CFG_AZ_RIGHT:  az_right  <= cfg_data[15:0];
        CFG_EL_LOWER:  el_lower  <= cfg_data[15:0];
        CFG_EL_UPPER:  el_upper  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // stage 1: offsets to the point of interest
  logic v1;
  logic signed [DIFF_W-1:0] dn1, de1, dd1;
  logic signed [15:0] sin1, cos1;
  logic [63:0] side1;

  always_ff @(posedge clk) begin
    if (en) begin
      dn1   <= DIFF_W'(poi_north) - DIFF_W'($signed(s_tdata[31:0]));
      de1   <= DIFF_W'(poi_east) - DIFF_W'($signed(s_tdata[63:32]));
      dd1   <= DIFF_W'(poi_down) - DIFF_W'($signed(s_tdata[95:64]));
      sin1  <= s_tdata[111:96];
      cos1  <= s_tdata[127:112];
      side1 <= s_tdata[191:128];
    end
  end

  // stage 2: heading rotation products
  logic v2;
  logic signed [PROD_W-1:0] p_nc, p_es, p_ec, p_ns;
  logic signed [DIFF_W-1:0] dd2;
  logic [63:0] side2;

  always_ff @(posedge clk) begin
    if (en) begin
      p_nc  <= PROD_W'(dn1) * PROD_W'(cos1);
      p_es  <= PROD_W'(de1) * PROD_W'(sin1);
      p_ec  <= PROD_W'(de1) * PROD_W'(cos1);
      p_ns  <= PROD_W'(dn1) * PROD_W'(sin1);
      dd2   <= dd1;
      side2 <= side1;
    end
  end

  // stage 3: rotated horizontal vector
  logic v3;
  logic signed [SUM_W-1:0] hx3, hy3;
  logic signed [DIFF_W-1:0] dd3;
  logic [63:0] side3;

  always_ff @(posedge clk) begin
    if (en) begin
      hx3   <= SUM_W'(p_nc) + SUM_W'(p_es);
      hy3   <= SUM_W'(p_ec) - SUM_W'(p_ns);
      dd3   <= dd2;
      side3 <= side2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= s_tvalid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  logic                   az_valid;
  logic [ANGLE_BITS-1:0]  az_ang;
  logic signed [CW-1:0]   az_mag;
  logic [PAY1_W-1:0]      az_pay;

  alap_cordic #(
    .STAGES(CORDIC_STAGES), .ANGLE_BITS(ANGLE_BITS), .PAY_W(PAY1_W)
  ) u_az_cordic (
    .clk, .rst, .en,
    .in_valid(v3),
    .in_x(CW'(hx3)),
    .in_y(CW'(hy3)),
    .in_pay({side3, dd3}),
    .out_valid(az_valid),
    .out_ang(az_ang),
    .out_mag(az_mag),
    .out_pay(az_pay)
  );

  // round half up when narrowing, shift up when widening
  function automatic logic [15:0] to_angle16(input logic [ANGLE_BITS-1:0] a);
    logic [ANGLE_BITS+1:0] v;
    v = {1'b0, a, 1'b0} + ((ANGLE_BITS+2)'(1) << ANG_SD);
    return 16'(v >> (ANG_SD + 1)) << ANG_SU;
  endfunction

  // stage 4: ground range with gain removed, vertical term
  logic v4;
  logic signed [CW-1:0] grng4, ey4;
  logic [15:0] az4;
  logic [63:0] side4;
  logic [CW-17:0] mag_hi;
  logic signed [CW-1:0] dd_ext;

  assign mag_hi = az_mag[CW-1] ? '0 : az_mag[CW-1:16];
  assign dd_ext = CW'($signed(az_pay[DIFF_W-1:0]));

  always_ff @(posedge clk) begin
    if (en) begin
      grng4 <= {16'b0, mag_hi} * {{(CW-16){1'b0}}, INV_GAIN_Q16};
      ey4   <= (-dd_ext) <<< 15;
      az4   <= to_angle16(az_ang);
      side4 <= az_pay[PAY1_W-1:DIFF_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= az_valid;
    end
  end

  logic                   el_valid;
  logic [ANGLE_BITS-1:0]  el_ang;
  logic signed [CW-1:0]   el_mag;
  logic [PAY2_W-1:0]      el_pay;

  alap_cordic #(
    .STAGES(CORDIC_STAGES), .ANGLE_BITS(ANGLE_BITS), .PAY_W(PAY2_W)
  ) u_el_cordic (
    .clk, .rst, .en,
    .in_valid(v4),
    .in_x(grng4),
    .in_y(ey4),
    .in_pay({side4, az4}),
    .out_valid(el_valid),
    .out_ang(el_ang),
    .out_mag(el_mag),
    .out_pay(el_pay)
  );

  // side fields above the azimuth: az_noise, el_noise, scan_width, scan_height
  logic [15:0] az_c, az_nz, el_nz, sw, sh;
  assign az_c  = el_pay[15:0];
  assign az_nz = el_pay[31:16];
  assign el_nz = el_pay[47:32];
  assign sw    = el_pay[63:48];
  assign sh    = el_pay[79:64];

  // stage 5: add noise, narrow the limits by half the scan, all modulo a turn
  logic v5;
  logic signed [15:0] az5, el5, az_lo5, az_hi5, el_lo5, el_hi5;
  logic el_mag_neg;
  assign el_mag_neg = el_mag[CW-1];

  always_ff @(posedge clk) begin
    if (en) begin
      az5    <= az_c + az_nz;
      el5    <= to_angle16(el_ang) + el_nz;
      az_lo5 <= az_left + {1'b0, sw[15:1]};
      az_hi5 <= az_right - {1'b0, sw[15:1]};
      el_lo5 <= el_lower + {1'b0, sh[15:1]};
      el_hi5 <= el_upper - {1'b0, sh[15:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (en) begin
      v5 <= el_valid && (el_mag_neg || !el_mag_neg);
    end
  end

  // output register: when the bounds cross, the lower wins below it, else the upper
  logic signed [15:0] az_out, el_out;

  always_ff @(posedge clk) begin
    if (en) begin
      priority if (az5 < az_lo5) az_out <= az_lo5;
      else if (az5 > az_hi5)     az_out <= az_hi5;
      else                       az_out <= az5;
      priority if (el5 < el_lo5) el_out <= el_lo5;
      else if (el5 > el_hi5)     el_out <= el_hi5;
      else                       el_out <= el5;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= v5;
    end
  end

  assign m_tdata = {el_out, az_out};

`include "antenna_look_angle_pointing_macros.svh"

  `ALAP_ASSERT_NOW(a_ready_when_empty, !m_tvalid, s_tready)
  `ALAP_ASSERT_NEXT(a_stall_holds_front, !en, v1 == $past(v1))
  `ALAP_ASSERT_NEXT(a_front_loads, en, v1 == $past(s_tvalid))

endmodule

// ===== rtl/alap_cordic.sv =====
// pipelined vectoring cordic: atan2 angle and magnitude, one stage per iteration
module alap_cordic #(
  parameter int STAGES = 16,
  parameter int ANGLE_BITS = 16,
  parameter int PAY_W = 1
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic signed [alap_pkg::CW-1:0] in_x,
  input  logic signed [alap_pkg::CW-1:0] in_y,
  input  logic [PAY_W-1:0]            in_pay,
  output logic                        out_valid,
  output logic [ANGLE_BITS-1:0]       out_ang,
  output logic signed [alap_pkg::CW-1:0] out_mag,
  output logic [PAY_W-1:0]            out_pay
);
  import alap_pkg::*;

  localparam int SH = 32 - ANGLE_BITS;

  logic signed [CW-1:0]   x     [STAGES+1];
  logic signed [CW-1:0]   y     [STAGES+1];
  logic [ANGLE_BITS-1:0]  ang   [STAGES+1];
  logic [PAY_W-1:0]       pay   [STAGES+1];
  logic                   zero  [STAGES+1];
  logic [STAGES:0]        valid;

  // entry stage: fold the left half plane onto the right
  always_ff @(posedge clk) begin
    if (rst) begin
      valid[0] <= 1'b0;
    end else if (en) begin
      valid[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      zero[0] <= (in_x == '0) && (in_y == '0);
      pay[0]  <= in_pay;
      if (in_x < 0) begin
        x[0]   <= -in_x;
        y[0]   <= -in_y;
        ang[0] <= ANGLE_BITS'(1) << (ANGLE_BITS - 1);
      end else begin
        x[0]   <= in_x;
        y[0]   <= in_y;
        ang[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    localparam logic [32:0] TR = ({1'b0, ATAN_TURN32[i]} + (33'd1 << (SH - 1))) >> SH;
    localparam logic [ANGLE_BITS-1:0] STEP = TR[ANGLE_BITS-1:0];

    always_ff @(posedge clk) begin
      if (rst) begin
        valid[i+1] <= 1'b0;
      end else if (en) begin
        valid[i+1] <= valid[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        zero[i+1] <= zero[i];
        pay[i+1]  <= pay[i];
        if (y[i] > 0) begin
          x[i+1]   <= x[i] + (y[i] >>> i);
          y[i+1]   <= y[i] - (x[i] >>> i);
          ang[i+1] <= ang[i] + STEP;
        end else begin
          x[i+1]   <= x[i] - (y[i] >>> i);
          y[i+1]   <= y[i] + (x[i] >>> i);
          ang[i+1] <= ang[i] - STEP;
        end
      end
    end
  end

  assign out_valid = valid[STAGES];
  assign out_ang   = zero[STAGES] ? '0 : ang[STAGES];
  assign out_mag   = zero[STAGES] ? '0 : x[STAGES];
  assign out_pay   = pay[STAGES];

endmodule

// ===== verif/antenna_look_angle_pointing_test.sv =====
// self-checking testbench for the look-angle pointing block
module antenna_look_angle_pointing_test;
  import alap_pkg::*;

  typedef struct packed {
    logic [15:0]        scan_height;
    logic [15:0]        scan_width;
    logic signed [15:0] el_noise;
    logic signed [15:0] az_noise;
    logic signed [15:0] heading_cosine;
    logic signed [15:0] heading_sine;
    logic signed [31:0] own_down;
    logic signed [31:0] own_east;
    logic signed [31:0] own_north;
  } fix_t;

  typedef struct packed {
    logic signed [15:0] el;
    logic signed [15:0] az;
  } look_t;

  localparam int WATCHDOG = 3000;
  localparam int DRAIN = 60;

  logic clk = 0;
  logic rst = 1;
  logic s_tvalid = 0;
  logic s_tready;
  // own_north, own_east, own_down, heading_sine, heading_cosine,
  // az_noise, el_noise, scan_width, scan_height
  logic [191:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 0;
  // ref_azimuth, ref_elevation
  logic [31:0] m_tdata;
  logic cfg_valid = 0;
  logic cfg_ready;
  cfg_reg_t cfg_index = CFG_POI_NORTH;
  logic [31:0] cfg_data = '0;

  antenna_look_angle_pointing u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // shadow of the pointing registers
  logic signed [31:0] poi_n = 0, poi_e = 0, poi_d = 0;
  logic signed [15:0] az_left = -16'sd32768, az_right = 16'sd32767;
  logic signed [15:0] el_lower = -16'sd16384, el_upper = 16'sd16384;

  fix_t  pending_fixes[$];
  look_t expected_looks[$];
  int    failures = 0;
  int    fixes_in = 0;
  int    quiet_cycles = 0;
  bit    steady = 0;

  function automatic logic [15:0] cordic_bearing(input longint x0, input longint y0,
                                                 output longint mag);
    longint x, y, nx, ny;
    logic [31:0] ang, step;
    x = x0;
    y = y0;
    ang = 0;
    if (x == 0 && y == 0) begin
      mag = 0;
      return 16'h0;
    end
    if (x < 0) begin
      x = -x;
      y = -y;
      ang = 32'h8000;
    end
    for (int i = 0; i < 16; i++) begin
      step = (ATAN_TURN32[i] + 32'h8000) >> 16;
      if (y > 0) begin
        nx = x + (y >>> i);
        ny = y - (x >>> i);
        ang = ang + step;
      end else begin
        nx = x - (y >>> i);
        ny = y + (x >>> i);
        ang = ang - step;
      end
      x = nx;
      y = ny;
    end
    mag = x;
    return ang[15:0];
  endfunction

  function automatic logic signed [15:0] clamp_look(input logic signed [15:0] a,
      input logic signed [15:0] lo_lim, input logic signed [15:0] hi_lim,
      input logic [15:0] span);
    logic signed [15:0] lo, hi;
    lo = lo_lim + (span >> 1);
    hi = hi_lim - (span >> 1);
    if (a < lo) return lo;
    if (a > hi) return hi;
    return a;
  endfunction

  function automatic look_t point_antenna(input fix_t f);
    longint dn, de, dd, s, c, x, y, mag, dummy, grng;
    logic signed [15:0] az, el;
    look_t r;
    dn = longint'(poi_n) - longint'(f.own_north);
    de = longint'(poi_e) - longint'(f.own_east);
    dd = longint'(poi_d) - longint'(f.own_down);
    s = longint'(f.heading_sine);
    c = longint'(f.heading_cosine);
    x = dn * c + de * s;
    y = de * c - dn * s;
    az = cordic_bearing(x, y, mag);
    if (mag < 0) mag = 0;
    grng = (mag >>> 16) * 39797;
    el = cordic_bearing(grng, -dd * 32768, dummy);
    az = az + f.az_noise;
    el = el + f.el_noise;
    r.az = clamp_look(az, az_left, az_right, f.scan_width);
    r.el = clamp_look(el, el_lower, el_upper, f.scan_height);
    return r;
  endfunction

  function automatic logic signed [31:0] near(input logic signed [31:0] base, input int bits);
    return base + ($signed($urandom_range(0, (1 << bits) - 1)) - (1 << (bits - 1)));
  endfunction

  function automatic fix_t random_fix();
    fix_t f;
    f = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    if ($urandom_range(0, 3) != 0) begin
      // plausible geometry near the point of interest with modest noise and scan
      f.own_north = near(poi_n, $urandom_range(4, 24));
      f.own_east = near(poi_e, $urandom_range(4, 24));
      f.own_down = near(poi_d, $urandom_range(4, 24));
      f.az_noise = 16'($signed($urandom_range(0, 511)) - 256);
      f.el_noise = 16'($signed($urandom_range(0, 511)) - 256);
      f.scan_width = 16'($urandom_range(0, 8000));
      f.scan_height = 16'($urandom_range(0, 8000));
    end
    return f;
  endfunction

  function automatic int next_gap();
    if (steady) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(5, 40);
    return $urandom_range(0, 2);
  endfunction

  // source side
  int src_gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 0;
    end else if (!s_tvalid || s_tready) begin
      if (src_gap > 0) begin
        src_gap--;
        s_tvalid <= 0;
      end else if (pending_fixes.size() > 0) begin
        s_tdata <= pending_fixes.pop_front();
        s_tvalid <= 1;
        src_gap = next_gap();
      end else begin
        s_tvalid <= 0;
      end
    end
  end

  // sink side, with one long hold-off to back up the pipeline
  int sink_gap = 0;
  int hold_left = 0;
  bit held = 0;
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 0;
    end else if (!held && fixes_in >= 150) begin
      held = 1;
      hold_left = 400;
      m_tready <= 0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_tready <= 0;
    end else if (sink_gap > 0) begin
      sink_gap--;
      m_tready <= 0;
    end else begin
      m_tready <= 1;
      sink_gap = next_gap();
    end
  end

  // monitor: register shadow, prediction and comparison
  always @(posedge clk) begin
    look_t want, got;
    if (!rst) begin
      quiet_cycles++;
      if (cfg_valid && cfg_ready) begin
        quiet_cycles = 0;
        case (cfg_index)
          CFG_POI_NORTH: poi_n = cfg_data;
          CFG_POI_EAST:  poi_e = cfg_data;
          CFG_POI_DOWN:  poi_d = cfg_data;
          CFG_AZ_LEFT:   az_left = cfg_data[15:0];
          CFG_AZ_RIGHT:  az_right = cfg_data[15:0];
          CFG_EL_LOWER:  el_lower = cfg_data[15:0];
          CFG_EL_UPPER:  el_upper = cfg_data[15:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        quiet_cycles = 0;
        fixes_in++;
        expected_looks.push_back(point_antenna(fix_t'(s_tdata)));
      end
      if (m_tvalid && m_tready) begin
        quiet_cycles = 0;
        got = m_tdata;
        if (expected_looks.size() == 0) begin
          failures++;
          $display("%0t unexpected beat expected none actual az=%0d el=%0d",
                   $time, got.az, got.el);
        end else begin
          want = expected_looks.pop_front();
          if (got.az !== want.az) begin
            failures++;
            $display("%0t azimuth mismatch expected %0d actual %0d", $time, want.az, got.az);
          end
          if (got.el !== want.el) begin
            failures++;
            $display("%0t elevation mismatch expected %0d actual %0d", $time, want.el, got.el);
          end
        end
      end
      if (quiet_cycles >= WATCHDOG) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  task automatic write_reg(input cfg_reg_t idx, input logic [31:0] val);
    @(posedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
  endtask

  task automatic drain();
    do @(negedge clk); while (pending_fixes.size() > 0 || s_tvalid ||
                             expected_looks.size() > 0);
    repeat (DRAIN) @(negedge clk);
  endtask

  task automatic add_fix(input logic signed [31:0] n, input logic signed [31:0] e,
                         input logic signed [31:0] d, input logic signed [15:0] s,
                         input logic signed [15:0] c, input logic signed [15:0] an,
                         input logic signed [15:0] en, input logic [15:0] sw,
                         input logic [15:0] sh);
    pending_fixes.push_back('{sh, sw, en, an, c, s, d, e, n});
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 0;

    // reset settings: zero vector, axes, quadrants, extremes
    add_fix(0, 0, 0, 0, 16'sh7fff, 0, 0, 0, 0);
    add_fix(-1000, 0, 0, 0, 16'sh7fff, 0, 0, 0, 0);
    add_fix(1000, 0, 0, 0, 16'sh7fff, 0, 0, 0, 0);
    add_fix(0, -1000, 500, 0, 16'sh7fff, 0, 0, 0, 0);
    add_fix(0, 1000, -500, 0, 16'sh7fff, 0, 0, 0, 0);
    add_fix(1000, 0, 0, 0, -16'sh8000, 0, 0, 0, 0);
    add_fix(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, -16'sh8000, -16'sh8000,
            -16'sh8000, -16'sh8000, 16'hffff, 16'hffff);
    add_fix(-32'sh80000000, -32'sh80000000, -32'sh80000000, 16'sh7fff, 16'sh7fff,
            16'sh7fff, 16'sh7fff, 16'hffff, 16'hffff);
    // negative x near a half turn, noise wraps past pi
    add_fix(1000, 1, 0, 0, 16'sh7fff, 16'sh7fff, 16'sh7fff, 0, 0);
    add_fix(1000, -1, 0, 0, 16'sh7fff, -16'sh8000, -16'sh8000, 1, 1);
    add_fix(-5000, 3000, 100, 23170, 23170, 100, -100, 16'h4000, 16'h2000);
    add_fix(5000, -3000, -100, -23170, 23170, 0, 0, 16'h8000, 16'h8000);
    // unnormalized heading
    add_fix(12345, -54321, 999, 16'sh7fff, 16'sh7fff, 0, 0, 0, 0);
    add_fix(12345, -54321, 999, 3, -2, 0, 0, 0, 0);
    drain();

    // extreme point of interest with crossed limits
    write_reg(CFG_POI_NORTH, 32'h7fffffff);
    write_reg(CFG_POI_EAST, 32'h80000000);
    write_reg(CFG_POI_DOWN, 32'h7fffffff);
    write_reg(CFG_AZ_LEFT, 32'h00001000);
    write_reg(CFG_AZ_RIGHT, 32'h0000f000);
    write_reg(CFG_EL_LOWER, 32'h00007fff);
    write_reg(CFG_EL_UPPER, 32'h00008000);
    write_reg(cfg_reg_t'(3'd7), 32'hdeadbeef);
    add_fix(0, 0, 0, 0, 16'sh7fff, 0, 0, 0, 0);
    add_fix(-32'sh80000000, 32'sh7fffffff, -32'sh80000000, 16'sh7fff, -16'sh8000,
            16'sh7fff, -16'sh8000, 0, 0);
    add_fix(32'sh7fffffff, -32'sh80000000, 32'sh7fffffff, 0, 16'sh7fff, 0, 0, 0, 0);
    for (int i = 0; i < 8; i++) pending_fixes.push_back(random_fix());
    drain();

    for (int phase = 0; phase < 8; phase++) begin
      write_reg(CFG_POI_NORTH, $urandom);
      write_reg(CFG_POI_EAST, $urandom);
      write_reg(CFG_POI_DOWN, phase == 0 ? 32'h80000000 : $urandom);
      write_reg(CFG_AZ_LEFT, phase == 1 ? 32'h8000 : $urandom_range(32768, 65535));
      write_reg(CFG_AZ_RIGHT, phase == 1 ? 32'h7fff : $urandom_range(0, 32767));
      write_reg(CFG_EL_LOWER, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(49152, 65535));
      write_reg(CFG_EL_UPPER, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 16384));
      steady = (phase == 3);
      for (int i = 0; i < 102; i++) pending_fixes.push_back(random_fix());
      drain();
    end

    if (failures == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/alap_pkg.sv
rtl/alap_cordic.sv
rtl/antenna_look_angle_pointing.sv
verif/antenna_look_angle_pointing_test.sv
